[design/pocis_pkg.sv]
// shared constants and types for the per-owner compacted id set
`default_nettype none

package pocis_pkg;

    // storage geometry
    localparam int OWNERS = 64;
    localparam int SLOTS  = 25;

    // fixed field widths
    localparam int ID_W       = 10;
    localparam int OP_W       = 2;
    localparam int OWNER_W    = 6;
    localparam int STATUS_W   = 2;
    localparam int OUT_SLOT_W = 5;

    // derived widths
    localparam int OWN_IDX_W = (OWNERS > 1) ? $clog2(OWNERS) : 1;
    localparam int SLOT_W    = $clog2(SLOTS + 1);
    localparam int DEPTH     = OWNERS * SLOTS;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef logic [ID_W-1:0]     id_t;
    typedef logic [OP_W-1:0]     op_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [SLOT_W-1:0]   slot_idx_t;
    typedef logic [ADDR_W-1:0]   addr_t;

    // largest identifier, also the reset limit
    localparam id_t ID_MAX = 10'h3FF;

    // operation codes
    localparam op_t OP_QUERY  = 2'd0;
    localparam op_t OP_LEARN  = 2'd1;
    localparam op_t OP_FORGET = 2'd2;

    // status codes
    localparam status_t ST_CHANGED   = 2'd0;
    localparam status_t ST_NO_CHANGE = 2'd1;
    localparam status_t ST_FULL      = 2'd2;
    localparam status_t ST_REJECTED  = 2'd3;

endpackage

`default_nettype wire

[design/per_owner_compacted_id_set_unit.sv]
// per-owner compacted id set: sequencer, row memory and count memory
`default_nettype none

// Keeps one list of up to SLOTS nonzero identifiers per owner in a row memory of
// OWNERS*SLOTS entries, plus a per-owner entry count in a small count memory.
// The occupied slots of a row always form a run from slot 0, so the count alone
// says which entries are live; a per-owner valid bit (cleared at reset) makes an
// untouched owner read as empty, so there is no clearing pass after reset and
// the block takes items right away. One item is handled at a time: the count is
// read, the live part of the row is streamed through the single read port one
// entry per cycle (forget writes each later entry one slot down as it streams
// past), then the insert or count update is written back. The result sits in
// an output register, so a new item is taken while an earlier result still
// waits on out_stall. max_valid_id is written through the cfg port, which is
// always ready.
module per_owner_compacted_id_set_unit
    import pocis_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // configuration write
    input  wire logic                  cfg_valid,
    output      logic                  cfg_ready,
    input  wire logic [ID_W-1:0]       max_valid_id,

    // input items
    input  wire logic                  in_valid,
    output      logic                  in_stall,
    input  wire logic [OP_W-1:0]       operation,
    input  wire logic [OWNER_W-1:0]    owner_id,
    input  wire logic                  owner_allied,
    input  wire logic [ID_W-1:0]       item_id,

    // result items
    output      logic                  out_valid,
    input  wire logic                  out_stall,
    output      logic                  found,
    output      logic [STATUS_W-1:0]   status,
    output      logic [OUT_SLOT_W-1:0] slot,
    output      logic [OUT_SLOT_W-1:0] entry_count
);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CNT  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    localparam slot_idx_t NO_SLOT = SLOT_W'(SLOTS);

    // control state
    logic [2:0]        state_reg, state_next;
    logic [OWNERS-1:0] row_vld_reg, row_vld_next;
    logic              out_valid_reg, out_valid_next;
    id_t               max_valid_id_reg, max_valid_id_next;

    // item context
    op_t               op_reg, op_next;
    id_t               item_reg, item_next;
    logic              owner_ok_reg, owner_ok_next;
    logic              active_reg, active_next;
    logic [OWN_IDX_W-1:0] own_reg, own_next;
    addr_t             base_reg, base_next;

    // scan state
    slot_idx_t         cnt_reg, cnt_next;
    slot_idx_t         rd_idx_reg, rd_idx_next;
    logic              chk_vld_reg, chk_vld_next;
    slot_idx_t         chk_idx_reg, chk_idx_next;
    logic              hit_reg, hit_next;
    slot_idx_t         where_reg, where_next;

    // finished result waiting for the output register
    logic              res_found_reg, res_found_next;
    status_t           res_status_reg, res_status_next;
    slot_idx_t         res_slot_reg, res_slot_next;
    slot_idx_t         res_count_reg, res_count_next;

    // output register payload
    logic              out_found_reg, out_found_next;
    status_t           out_status_reg, out_status_next;
    slot_idx_t         out_slot_reg, out_slot_next;
    slot_idx_t         out_count_reg, out_count_next;

    // row memory: one 10-bit identifier per slot
    id_t               row_mem [DEPTH];
    id_t               row_rdata_reg;
    logic              row_re;
    addr_t             row_raddr;
    logic              row_we;
    addr_t             row_waddr;
    id_t               row_wdata;

    // count memory: live entries per owner
    slot_idx_t         cnt_mem [OWNERS];
    slot_idx_t         cnt_rdata_reg;
    logic              cnt_re;
    logic              cnt_we;
    slot_idx_t         cnt_wdata;

    // input side decode
    logic              in_xfer;
    logic              out_xfer;
    logic [OWN_IDX_W-1:0] own_idx;
    logic              owner_ok;
    logic              id_ok;
    logic              op_active;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_xfer  = out_valid_reg && !out_stall;

    assign out_valid   = out_valid_reg;
    assign found       = out_found_reg;
    assign status      = out_status_reg;
    assign slot        = OUT_SLOT_W'(out_slot_reg);
    assign entry_count = OUT_SLOT_W'(out_count_reg);

    assign own_idx  = OWN_IDX_W'(owner_id);
    assign owner_ok = (int'(owner_id) < OWNERS);
    assign id_ok    = (item_id != '0) && (item_id <= max_valid_id_reg);

    // an item that is not rejected outright needs the row scanned
    always_comb
    begin
        op_active = 1'b0;
        case (operation)
            OP_QUERY:  op_active = 1'b1;
            OP_LEARN:  op_active = owner_allied;
            OP_FORGET: op_active = 1'b1;
            default:   op_active = 1'b0;
        endcase
    end

    assign cnt_re = in_xfer;

    // sequencer and datapath next-state logic
    always_comb
    begin
        state_next        = state_reg;
        row_vld_next      = row_vld_reg;
        out_valid_next    = out_valid_reg;
        max_valid_id_next = max_valid_id_reg;

        op_next       = op_reg;
        item_next     = item_reg;
        owner_ok_next = owner_ok_reg;
        active_next   = active_reg;
        own_next      = own_reg;
        base_next     = base_reg;

        cnt_next     = cnt_reg;
        rd_idx_next  = rd_idx_reg;
        chk_vld_next = 1'b0;
        chk_idx_next = chk_idx_reg;
        hit_next     = hit_reg;
        where_next   = where_reg;

        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_count_next  = res_count_reg;

        out_found_next  = out_found_reg;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_count_next  = out_count_reg;

        row_re    = 1'b0;
        row_raddr = base_reg + ADDR_W'(rd_idx_reg);
        row_we    = 1'b0;
        row_waddr = base_reg + ADDR_W'(cnt_reg);
        row_wdata = item_reg;
        cnt_we    = 1'b0;
        cnt_wdata = cnt_reg;

        // config is to be written by the user only while idle; the block does not enforce this
        if (cfg_valid)
        begin
            max_valid_id_next = max_valid_id;
        end

        // output register drains independently of the sequencer
        if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    op_next       = operation;
                    item_next     = item_id;
                    owner_ok_next = owner_ok;
                    active_next   = owner_ok && id_ok && op_active;
                    own_next      = own_idx;
                    base_next     = ADDR_W'(int'(own_idx) * SLOTS);
                    state_next    = S_CNT;
                end
            end

            S_CNT:
            begin
                // untouched owners read as empty
                cnt_next    = row_vld_reg[own_reg] ? cnt_rdata_reg : '0;
                rd_idx_next = '0;
                hit_next    = 1'b0;
                where_next  = NO_SLOT;
                state_next  = active_reg ? S_SCAN : S_FIN;
            end

            S_SCAN:
            begin
                // issue one read per cycle over the live run
                if (rd_idx_reg < cnt_reg)
                begin
                    row_re       = 1'b1;
                    rd_idx_next  = rd_idx_reg + 1'b1;
                    chk_vld_next = 1'b1;
                    chk_idx_next = rd_idx_reg;
                end

                // check the entry read last cycle
                if (chk_vld_reg)
                begin
                    if (!hit_reg && (row_rdata_reg == item_reg))
                    begin
                        hit_next   = 1'b1;
                        where_next = chk_idx_reg;
                    end
                    else if (hit_reg && (op_reg == OP_FORGET))
                    begin
                        // compaction: move the entry one slot down
                        row_we    = 1'b1;
                        row_waddr = base_reg + ADDR_W'(chk_idx_reg - 1'b1);
                        row_wdata = row_rdata_reg;
                    end
                end

                if (!(rd_idx_reg < cnt_reg) && !chk_vld_reg)
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                res_found_next  = 1'b0;
                res_status_next = ST_REJECTED;
                res_slot_next   = NO_SLOT;
                res_count_next  = owner_ok_reg ? cnt_reg : '0;

                if (active_reg)
                begin
                    case (op_reg)
                        OP_QUERY:
                        begin
                            res_found_next  = hit_reg;
                            res_status_next = ST_NO_CHANGE;
                            res_slot_next   = where_reg;
                        end
                        OP_LEARN:
                        begin
                            if (hit_reg)
                            begin
                                res_found_next  = 1'b1;
                                res_status_next = ST_NO_CHANGE;
                                res_slot_next   = where_reg;
                            end
                            else if (cnt_reg < NO_SLOT)
                            begin
                                // append at the end of the run
                                row_we          = 1'b1;
                                row_waddr       = base_reg + ADDR_W'(cnt_reg);
                                row_wdata       = item_reg;
                                cnt_we          = 1'b1;
                                cnt_wdata       = cnt_reg + 1'b1;
                                res_status_next = ST_CHANGED;
                                res_slot_next   = cnt_reg;
                                res_count_next  = cnt_reg + 1'b1;
                            end
                            else
                            begin
                                res_status_next = ST_FULL;
                            end
                        end
                        OP_FORGET:
                        begin
                            if (hit_reg)
                            begin
                                cnt_we          = 1'b1;
                                cnt_wdata       = cnt_reg - 1'b1;
                                res_found_next  = 1'b1;
                                res_status_next = ST_CHANGED;
                                res_slot_next   = where_reg;
                                res_count_next  = cnt_reg - 1'b1;
                            end
                            else
                            begin
                                res_status_next = ST_NO_CHANGE;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_REJECTED;
                        end
                    endcase
                end

                if (cnt_we)
                begin
                    row_vld_next[own_reg] = 1'b1;
                end
                state_next = S_OUT;
            end

            S_OUT:
            begin
                // hand over once the output register is free
                if (!out_valid_reg || out_stall == 1'b0)
                begin
                    out_valid_next  = 1'b1;
                    out_found_next  = res_found_reg;
                    out_status_next = res_status_reg;
                    out_slot_next   = res_slot_reg;
                    out_count_next  = res_count_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            row_vld_reg      <= '0;
            out_valid_reg    <= 1'b0;
            max_valid_id_reg <= ID_MAX;
            chk_vld_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            row_vld_reg      <= row_vld_next;
            out_valid_reg    <= out_valid_next;
            max_valid_id_reg <= max_valid_id_next;
            chk_vld_reg      <= chk_vld_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        item_reg        <= item_next;
        owner_ok_reg    <= owner_ok_next;
        active_reg      <= active_next;
        own_reg         <= own_next;
        base_reg        <= base_next;
        cnt_reg         <= cnt_next;
        rd_idx_reg      <= rd_idx_next;
        chk_idx_reg     <= chk_idx_next;
        hit_reg         <= hit_next;
        where_reg       <= where_next;
        res_found_reg   <= res_found_next;
        res_status_reg  <= res_status_next;
        res_slot_reg    <= res_slot_next;
        res_count_reg   <= res_count_next;
        out_found_reg   <= out_found_next;
        out_status_reg  <= out_status_next;
        out_slot_reg    <= out_slot_next;
        out_count_reg   <= out_count_next;
    end

    // row memory, registered read
    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[row_waddr] <= row_wdata;
        end
        if (row_re)
        begin
            row_rdata_reg <= row_mem[row_raddr];
        end
    end

    // count memory, registered read
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[own_reg] <= cnt_wdata;
        end
        if (cnt_re)
        begin
            cnt_rdata_reg <= cnt_mem[own_idx];
        end
    end

    // a scanned run never exceeds the row length
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (cnt_reg <= NO_SLOT))
        else $error("entry count beyond row length during scan");

    // row writes only come from forget compaction or a learn append
    assert property (@(posedge clk) disable iff (!rst_n)
        row_we |-> ((state_reg == S_SCAN && op_reg == OP_FORGET && hit_reg)
                 || (state_reg == S_FIN && op_reg == OP_LEARN)))
        else $error("unexpected row memory write");

    // compaction write stays behind the read pointer
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && chk_vld_reg) |-> (rd_idx_reg == chk_idx_reg + 1'b1))
        else $error("scan read and check out of step");

    // a new result only appears from the hand-over state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_OUT))
        else $error("result transfer raised outside hand-over");

endmodule

`default_nettype wire
